// ===== rtl/penalized_coordinate_threshold_macros.svh =====
// Assertion macros for the penalized coordinate threshold block.
`ifndef PENALIZED_COORDINATE_THRESHOLD_MACROS_SVH
`define PENALIZED_COORDINATE_THRESHOLD_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define PCT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("penalized_coordinate_threshold: check failed");

// The consequent holds in the cycle after the antecedent.
`define PCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("penalized_coordinate_threshold: check failed");

`endif

// ===== rtl/pct_pkg.sv =====
// Package with constants and codes for the penalized coordinate threshold block.
package pct_pkg;

  localparam int DW     = 32;
  localparam int FB     = 16;
  localparam int NUM_W  = 96;
  localparam int DEN_W  = 65;
  localparam int QB     = 32;
  localparam int CFG_IW = 2;

  typedef enum logic [2:0] {
    K_RIDGE  = 3'd0,
    K_LASSO  = 3'd1,
    K_MCP    = 3'd2,
    K_SCAD   = 3'd3,
    K_ENET   = 3'd4,
    K_GMCP   = 3'd5,
    K_GSCAD  = 3'd6,
    K_GLASSO = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2,
    ST_RSVD = 2'd3
  } status_t;

  typedef enum logic [CFG_IW-1:0] {
    R_KIND  = 2'd0,
    R_LAMBDA = 2'd1,
    R_GAMMA = 2'd2,
    R_ALPHA = 2'd3
  } reg_idx_t;

  localparam logic [DW-1:0] ONE_FX     = 32'd1 << FB;
  localparam logic [16:0]   ALPHA_ONE  = 17'd65536;
  localparam logic [DW-1:0] RST_LAMBDA = 32'd65536;
  localparam logic [DW-1:0] RST_GAMMA  = 32'd242483;

  typedef struct packed {
    logic zero;
    logic neg;
    logic dz;
    logic ovf;
  } flg_t;

endpackage

// ===== rtl/penalized_coordinate_threshold.sv =====
// Penalized coordinate-descent threshold update, fully pipelined.
// 40 register stages in all; the 32 restoring divider steps are one stage each.
// Throughput: one item per cycle while the output is not stalled.
// Each stage stalls only when it holds an item and the stage after it cannot take it.
// Reset (rst, synchronous) clears all valid bits and loads the register defaults.
module penalized_coordinate_threshold
  import pct_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // gradient[31:0], curvature[63:32], coefficient[95:64], group_z[127:96]
  input  logic [127:0]      s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // new_coefficient[31:0], status[33:32], zero fill above
  output logic [39:0]       m_tdata,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [DW-1:0]     cfg_data
);

  localparam int DS = 6;
  localparam int NS = DS + QB + 2;

  kind_t         penalty_kind;
  logic [DW-1:0] lambda_level;
  logic [DW-1:0] gamma_shape;
  logic [16:0]   mix_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      penalty_kind <= K_LASSO;
      lambda_level <= RST_LAMBDA;
      gamma_shape  <= RST_GAMMA;
      mix_alpha    <= ALPHA_ONE;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        R_KIND:   penalty_kind <= kind_t'(cfg_data[2:0]);
        R_LAMBDA: lambda_level <= cfg_data;
        R_GAMMA:  gamma_shape  <= cfg_data;
        R_ALPHA:  mix_alpha    <= cfg_data[16:0];
        default:  penalty_kind <= penalty_kind;
      endcase
    end
  end

  logic [NS-1:0] v;
  logic [NS-1:0] rdy;

  always_comb begin
    rdy[NS-1] = !v[NS-1] || m_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= s_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  assign s_tready = rdy[0];

  // Stage A: capture the item and a copy of the configuration.
  logic [DW-1:0] a_g, a_h, a_c, a_gz, a_lam, a_gam;
  logic [16:0]   a_al;
  kind_t         a_kind;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a_g    <= s_tdata[31:0];
      a_h    <= s_tdata[63:32];
      a_c    <= s_tdata[95:64];
      a_gz   <= s_tdata[127:96];
      a_kind <= penalty_kind;
      a_lam  <= lambda_level;
      a_gam  <= gamma_shape;
      a_al   <= (mix_alpha > ALPHA_ONE) ? ALPHA_ONE : mix_alpha;
    end
  end

  // Stage B: magnitudes and the first products.
  logic [DW-1:0] am, gm, zgm;
  assign am  = a_c[DW-1]  ? (~a_c + 32'd1)  : a_c;
  assign gm  = a_g[DW-1]  ? (~a_g + 32'd1)  : a_g;
  assign zgm = a_gz[DW-1] ? (~a_gz + 32'd1) : a_gz;

  logic [63:0]   b_pha, b_gl;
  logic [47:0]   b_gms;
  logic [48:0]   b_lal, b_lnal;
  logic [DW-1:0] b_zgm, b_h, b_lam, b_gam;
  logic          b_an, b_gn, b_zgn;
  kind_t         b_kind;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      b_pha  <= 64'(a_h) * 64'(am);
      b_gms  <= {gm, 16'd0};
      b_lal  <= 49'(a_lam) * 49'(a_al);
      b_lnal <= 49'(a_lam) * 49'(ALPHA_ONE - a_al);
      b_gl   <= 64'(a_gam) * 64'(a_lam);
      b_zgm  <= zgm;
      b_zgn  <= a_gz[DW-1];
      b_an   <= a_c[DW-1];
      b_gn   <= !a_g[DW-1];
      b_h    <= a_h;
      b_lam  <= a_lam;
      b_gam  <= a_gam;
      b_kind <= a_kind;
    end
  end

  // Stage C: z as sign and magnitude.
  logic [63:0] z_n, u_w;
  logic        zn_n;
  assign u_w = {16'd0, b_gms};

  always_comb begin
    if (b_kind == K_GMCP || b_kind == K_GSCAD || b_kind == K_GLASSO) begin
      z_n  = {16'd0, b_zgm, 16'd0};
      zn_n = b_zgn;
    end else if (b_an == b_gn) begin
      z_n  = b_pha + u_w;
      zn_n = b_an;
    end else if (b_pha >= u_w) begin
      z_n  = b_pha - u_w;
      zn_n = b_an;
    end else begin
      z_n  = u_w - b_pha;
      zn_n = b_gn;
    end
    if (z_n == 64'd0) zn_n = 1'b0;
  end

  logic [63:0]   c_z, c_gl;
  logic          c_zn;
  logic [48:0]   c_lal, c_lnal;
  logic [DW-1:0] c_h, c_lam, c_gam;
  kind_t         c_kind;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      c_z    <= z_n;
      c_zn   <= zn_n;
      c_gl   <= b_gl;
      c_lal  <= b_lal;
      c_lnal <= b_lnal;
      c_h    <= b_h;
      c_lam  <= b_lam;
      c_gam  <= b_gam;
      c_kind <= b_kind;
    end
  end

  // Stage D: pick the threshold band and the operands of the quotient.
  logic [63:0]   lam_s, zml, nb_n, sub_n;
  logic [DW-1:0] f_n, df_n;
  logic [48:0]   dadd_n;
  logic          zero_n, le_l, le_2l, le_gl, le_en;

  assign lam_s = {16'd0, c_lam, 16'd0};
  assign zml   = c_z - lam_s;
  assign le_l  = c_z <= lam_s;
  assign le_2l = c_z <= {lam_s[62:0], 1'b0};
  assign le_gl = c_z <= c_gl;
  assign le_en = c_z <= {15'd0, c_lal};

  always_comb begin
    zero_n = 1'b0;
    nb_n   = c_z;
    f_n    = 32'd1;
    sub_n  = 64'd0;
    df_n   = 32'd1;
    dadd_n = 49'd0;
    case (c_kind)
      K_RIDGE: begin
        dadd_n = {17'd0, c_lam};
      end
      K_ENET: begin
        zero_n = le_en;
        nb_n   = c_z - {15'd0, c_lal};
        f_n    = ONE_FX;
        df_n   = ONE_FX;
        dadd_n = c_lnal;
      end
      K_MCP, K_GMCP: begin
        zero_n = le_l;
        if (le_gl) begin
          nb_n = zml;
          f_n  = c_gam;
          df_n = c_gam - ONE_FX;
        end
      end
      K_SCAD, K_GSCAD: begin
        zero_n = le_l;
        if (le_2l) begin
          nb_n = zml;
        end else if (le_gl) begin
          f_n   = c_gam - ONE_FX;
          sub_n = c_gl;
          df_n  = c_gam - {ONE_FX[DW-2:0], 1'b0};
        end
      end
      default: begin
        zero_n = le_l;
        nb_n   = zml;
      end
    endcase
  end

  logic [63:0]   d_nb, d_sub;
  logic [DW-1:0] d_f, d_df, d_h;
  logic [48:0]   d_dadd;
  logic          d_zero, d_zn;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      d_nb   <= nb_n;
      d_f    <= f_n;
      d_sub  <= sub_n;
      d_df   <= df_n;
      d_dadd <= dadd_n;
      d_h    <= c_h;
      d_zero <= zero_n;
      d_zn   <= c_zn;
    end
  end

  // Stage E: partial products of numerator and denominator.
  logic [63:0] e_plo, e_phi, e_hd, e_sub;
  logic [48:0] e_dadd;
  logic        e_zero, e_zn;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      e_plo  <= 64'(d_nb[31:0]) * 64'(d_f);
      e_phi  <= 64'(d_nb[63:32]) * 64'(d_f);
      e_hd   <= 64'(d_h) * 64'(d_df);
      e_sub  <= d_sub;
      e_dadd <= d_dadd;
      e_zero <= d_zero;
      e_zn   <= d_zn;
    end
  end

  // Stage F: final numerator and denominator.
  logic [NUM_W-1:0] f_num;
  logic [DEN_W-1:0] f_den;
  logic             f_zero, f_zn;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      f_num  <= {e_phi, 32'd0} + {32'd0, e_plo} - {16'd0, e_sub, 16'd0};
      f_den  <= {1'b0, e_hd} + {16'd0, e_dadd};
      f_zero <= e_zero;
      f_zn   <= e_zn;
    end
  end

  // Stage G and the divider: one quotient bit per stage.
  logic [NUM_W-1:0] q_rem [QB+1];
  logic [DEN_W-1:0] q_den [QB+1];
  logic [QB-1:0]    q_q   [QB+1];
  flg_t             q_flg [QB+1];

  always_ff @(posedge clk) begin
    if (rdy[DS]) begin
      q_rem[0]      <= f_num;
      q_den[0]      <= f_den;
      q_q[0]        <= '0;
      q_flg[0].zero <= f_zero;
      q_flg[0].neg  <= f_zn;
      q_flg[0].dz   <= f_den == '0;
      q_flg[0].ovf  <= {1'b0, f_num} >= {f_den, 32'd0};
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_div
    localparam int BIT = QB - j;
    logic [NUM_W:0] dsh;
    logic           ge;
    assign dsh = {{(NUM_W + 1 - DEN_W){1'b0}}, q_den[j-1]} << BIT;
    assign ge  = {1'b0, q_rem[j-1]} >= dsh;

    always_ff @(posedge clk) begin
      if (rdy[DS+j]) begin
        q_rem[j]      <= ge ? (q_rem[j-1] - dsh[NUM_W-1:0]) : q_rem[j-1];
        q_den[j]      <= q_den[j-1];
        q_q[j]        <= q_q[j-1] | ({{(QB - 1){1'b0}}, ge} << BIT);
        q_flg[j]      <= q_flg[j-1];
      end
    end
  end

  // Output stage: zero and divide-by-zero cases, saturation and sign.
  flg_t          fl;
  logic [DW-1:0] lim, mq, coef_n;
  status_t       st_n;
  assign fl  = q_flg[QB];
  assign mq  = q_q[QB];
  assign lim = fl.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;

  always_comb begin
    if (fl.zero) begin
      coef_n = '0;
      st_n   = ST_OK;
    end else if (fl.dz) begin
      coef_n = '0;
      st_n   = ST_DIVZ;
    end else if (fl.ovf || mq > lim) begin
      coef_n = fl.neg ? (~lim + 32'd1) : lim;
      st_n   = ST_SAT;
    end else begin
      coef_n = fl.neg ? (~mq + 32'd1) : mq;
      st_n   = ST_OK;
    end
  end

  logic [DW-1:0] o_coef;
  status_t       o_status;

  always_ff @(posedge clk) begin
    if (rdy[NS-1]) begin
      o_coef   <= coef_n;
      o_status <= st_n;
    end
  end

  assign m_tvalid = v[NS-1];
  assign m_tdata  = {6'd0, o_status, o_coef};

`include "penalized_coordinate_threshold_macros.svh"

  `PCT_ASSERT_NEXT(a_enter, s_tvalid && s_tready, v[0])
  `PCT_ASSERT_NOW(a_divz_zero, m_tvalid && o_status == ST_DIVZ, o_coef == '0)
  `PCT_ASSERT_NOW(a_sat_limit, m_tvalid && o_status == ST_SAT, o_coef == 32'h7FFF_FFFF || o_coef == 32'h8000_0000)
  `PCT_ASSERT_NOW(a_status_code, m_tvalid, o_status != ST_RSVD)

endmodule

// ===== bench/penalized_coordinate_threshold_test.sv =====
// Self-checking testbench for the penalized coordinate threshold block, with its own predictor.
module penalized_coordinate_threshold_test
  import pct_pkg::*;
();

  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [DW-1:0] MAX_POS = 32'h7fffffff;
  localparam logic [DW-1:0] MAX_NEG = 32'h80000000;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [127:0]      s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [39:0]       m_tdata;
  logic              cfg_we;
  reg_idx_t          cfg_index;
  logic [DW-1:0]     cfg_data;

  kind_t             penalty;
  logic [DW-1:0]     lambda_q;
  logic [DW-1:0]     gamma_q;
  logic [16:0]       alpha_q;

  logic [DW-1:0]     coef_due[$];
  status_t           status_due[$];
  int                mismatches;
  int                results_seen;
  int                items_sent;
  int                cycle_count;
  int                rx_hold;
  bit                tx_quiet;
  bit                rx_quiet;

  penalized_coordinate_threshold dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("[penalized_coordinate_threshold] ERROR");
      $finish;
    end
  end

  // Truncating division with saturation to the signed coefficient range, and a divide-by-zero status.
  function automatic void divide_sat(input bit neg, input bit [127:0] num,
                                     input bit [127:0] den, output logic [DW-1:0] q,
                                     output status_t st);
    bit [127:0] quo;
    bit [127:0] lim;
    if (den == 0) begin
      q = '0;
      st = ST_DIVZ;
    end else begin
      quo = num / den;
      lim = neg ? 128'h80000000 : 128'h7fffffff;
      st = ST_OK;
      if (quo > lim) begin
        quo = lim;
        st = ST_SAT;
      end
      q = neg ? -quo[31:0] : quo[31:0];
    end
  endfunction

  function automatic void predict_update(input logic [DW-1:0] g, input logic [DW-1:0] h,
                                         input logic [DW-1:0] c, input logic [DW-1:0] gz,
                                         output logic [DW-1:0] q, output status_t st);
    bit [127:0] z, t, u, lam_s, gl, num, den, thr, sc;
    bit [127:0] lam, gam, hh, al;
    bit zn, an, gn;
    bit [31:0] am, gm;
    sc = 128'd1 << FB;
    lam = lambda_q;
    gam = gamma_q;
    hh = h;
    if (penalty >= K_GMCP) begin
      zn = gz[31];
      am = zn ? -gz : gz;
      z = 128'(am) << FB;
    end else begin
      an = c[31];
      am = an ? -c : c;
      gn = ~g[31];
      gm = g[31] ? -g : g;
      t = hh * 128'(am);
      u = 128'(gm) << FB;
      if (an == gn) begin
        z = t + u;
        zn = an;
      end else if (t >= u) begin
        z = t - u;
        zn = an;
      end else begin
        z = u - t;
        zn = gn;
      end
      if (z == 0) zn = 1'b0;
    end
    lam_s = lam << FB;
    gl = gam * lam;
    q = '0;
    st = ST_OK;
    case (penalty)
      K_RIDGE: divide_sat(zn, z, hh + lam, q, st);
      K_ENET: begin
        al = (alpha_q > ALPHA_ONE) ? 128'(ALPHA_ONE) : 128'(alpha_q);
        thr = (lam * al) << FB;
        num = z << 16;
        if (num > thr) begin
          den = (hh << 16) + lam * (128'd65536 - al);
          divide_sat(zn, num - thr, den, q, st);
        end
      end
      default: begin
        if (z > lam_s) begin
          if (penalty == K_LASSO || penalty == K_GLASSO) begin
            divide_sat(zn, z - lam_s, hh, q, st);
          end else if (penalty == K_MCP || penalty == K_GMCP) begin
            if (z <= gl) divide_sat(zn, (z - lam_s) * gam, hh * (gam - sc), q, st);
            else divide_sat(zn, z, hh, q, st);
          end else if (z <= 2 * lam_s) begin
            divide_sat(zn, z - lam_s, hh, q, st);
          end else if (z <= gl) begin
            divide_sat(zn, z * (gam - sc) - (gl << FB), hh * (gam - 2 * sc), q, st);
          end else begin
            divide_sat(zn, z, hh, q, st);
          end
        end
      end
    endcase
  endfunction

  // Result side: checks each transfer and drives the ready with random stalls.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (coef_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %h.", m_tdata);
        end else begin
          if (m_tdata[31:0] !== coef_due[0] || m_tdata[33:32] !== status_due[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Result %0d: expected %h/%0d, got %h/%0d.", results_seen,
                       coef_due[0], status_due[0], m_tdata[31:0], m_tdata[33:32]);
          end
          void'(coef_due.pop_front());
          void'(status_due.pop_front());
        end
      end
      if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= rx_quiet || ($urandom_range(99) >= 27);
      end
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input kind_t k, input logic [DW-1:0] lam,
                            input logic [DW-1:0] gam, input logic [16:0] al);
    write_reg(R_KIND, DW'(k));
    write_reg(R_LAMBDA, lam);
    write_reg(R_GAMMA, gam);
    write_reg(R_ALPHA, DW'(al));
    cfg_we <= 1'b0;
    penalty = k;
    lambda_q = lam;
    gamma_q = gam;
    alpha_q = al;
  endtask

  task automatic send_item(input logic [DW-1:0] g, input logic [DW-1:0] h,
                           input logic [DW-1:0] c, input logic [DW-1:0] gz);
    logic [DW-1:0] q;
    status_t st;
    while (!tx_quiet && $urandom_range(99) < 27) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {gz, c, h, g};
    do @(posedge clk); while (!s_tready);
    predict_update(g, h, c, gz, q, st);
    coef_due.push_back(q);
    status_due.push_back(st);
    items_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (coef_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [DW-1:0] pick_word();
    case ($urandom_range(5))
      0: return $urandom();
      1: return DW'($urandom_range(32'h3ffff));
      2: return -DW'($urandom_range(32'h3ffff));
      3: return MAX_POS;
      4: return MAX_NEG;
      default: return DW'($urandom_range(2)) - 1;
    endcase
  endfunction

  // Group z near a small multiple of a quarter of lambda (or a random word), so that every band is reached.
  function automatic logic [DW-1:0] pick_z();
    logic [DW-1:0] m;
    if ($urandom_range(2) == 0) return pick_word();
    m = (lambda_q >> 2) * DW'($urandom_range(24)) + DW'($urandom_range(3)) - 1;
    return $urandom_range(1) ? -m : m;
  endfunction

  function automatic logic [DW-1:0] pick_curv();
    case ($urandom_range(3))
      0: return '0;
      1: return $urandom();
      default: return DW'($urandom_range(32'h2ffff));
    endcase
  endfunction

  task automatic test_defaults();
    send_item(32'h00010000, 32'h00010000, 32'h00030000, 32'd0);
    send_item(32'hffff0000, 32'h00010000, 32'hfffd0000, 32'd0);
    send_item(32'h00008000, 32'h00010000, 32'h00018000, 32'd0);
    wait_idle();
  endtask

  task automatic test_directed();
    kind_t k;
    k = k.first();
    do begin
      set_config(k, 32'h00010000, 32'h0003b333, 17'd65536);
      send_item(MAX_NEG, 32'hffffffff, MAX_POS, MAX_NEG);
      send_item(MAX_POS, 32'd0, MAX_NEG, MAX_POS);
      send_item(32'hffff0000, 32'h00010000, 32'h00010000, 32'h00028000);
      wait_idle();
      k = k.next();
    end while (k != k.first());
    set_config(K_RIDGE, 32'd0, 32'd65537, 17'd0);
    send_item(32'h00010000, 32'd0, 32'd5, 32'd0);
    wait_idle();
    set_config(K_ENET, 32'h00020000, 32'd65537, 17'h1ffff);
    send_item(32'h00050000, 32'd0, 32'd0, 32'd0);
    wait_idle();
    set_config(K_MCP, 32'h00010000, 32'd65537, 17'd0);
    send_item(32'hfffe0000, 32'h00010000, 32'd0, 32'd0);
    wait_idle();
    set_config(K_SCAD, 32'h00010000, 32'h00018000, 17'd0);
    send_item(32'hfffd0000, 32'h00010000, 32'd0, 32'd0);
    wait_idle();
  endtask

  task automatic test_random(input int phases, input int per_phase);
    logic [DW-1:0] lam, gam;
    logic [16:0] al;
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(3))
        0: lam = '0;
        1: lam = 32'hffffffff;
        2: lam = $urandom();
        default: lam = DW'($urandom_range(32'h4ffff));
      endcase
      case ($urandom_range(4))
        0: gam = 32'd65537;
        1: gam = 32'hffffffff;
        2: gam = $urandom_range(32'hffffffff, 32'd65537);
        default: gam = $urandom_range(32'h7ffff, 32'd65537);
      endcase
      case ($urandom_range(3))
        0: al = 17'd0;
        1: al = 17'h1ffff;
        default: al = 17'($urandom_range(65536));
      endcase
      set_config(kind_t'($urandom_range(7)), lam, gam, al);
      tx_quiet = (p % 5 == 2);
      rx_quiet = tx_quiet;
      for (int i = 0; i < per_phase; i++)
        send_item(pick_word(), pick_curv(), pick_word(), pick_z());
      wait_idle();
    end
    tx_quiet = 0;
    rx_quiet = 0;
  endtask

  task automatic test_backpressure();
    set_config(K_SCAD, 32'h00020000, 32'h0003b333, 17'd32768);
    tx_quiet = 1;
    rx_hold = 200;
    for (int i = 0; i < 90; i++)
      send_item(pick_word(), pick_curv(), pick_word(), pick_z());
    tx_quiet = 0;
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = R_KIND;
    cfg_data = '0;
    cycle_count = 0;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    rx_hold = 0;
    tx_quiet = 0;
    rx_quiet = 0;
    penalty = K_LASSO;
    lambda_q = RST_LAMBDA;
    gamma_q = RST_GAMMA;
    alpha_q = ALPHA_ONE;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_directed();
    test_backpressure();
    test_random(16, 100);
    $display("Sent %0d coordinates over all eight penalties and %0d configurations;",
             items_sent, 29);
    $display("checked %0d updates, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0 && coef_due.size() == 0) begin
      $display("[penalized_coordinate_threshold] OK");
    end else begin
      $display("[penalized_coordinate_threshold] ERROR");
    end
    $finish;
  end

endmodule
